@@ rtl/dqmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqmb_pkg
// Shared constants, codes and controller/datapath interface types for the
// query message builder.
// ----------------------------------------------------------------------------
package dqmb_pkg;

    localparam int BYTE_W    = 8;
    localparam int MAX_LABEL = 32;                   // 1 .. 63
    localparam int LABEL_AW  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int FILL_W    = $clog2(MAX_LABEL + 1);

    localparam int HDR_LEN   = 12;
    localparam int TRL_LEN   = 5;                    // terminator, type, class
    localparam int CNT_W     = 4;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUESTION_TYPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUESTION_CLASS = 2'd3;

    localparam logic [CFG_W-1:0] RST_QUERY_ID       = 16'h08BB;
    localparam logic [CFG_W-1:0] RST_HEADER_FLAGS   = 16'h0100;
    localparam logic [CFG_W-1:0] RST_QUESTION_TYPE  = 16'h0001;
    localparam logic [CFG_W-1:0] RST_QUESTION_CLASS = 16'h0001;

    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

    // output byte source select
    localparam logic [1:0] SRC_HDR  = 2'd0;
    localparam logic [1:0] SRC_LEN  = 2'd1;
    localparam logic [1:0] SRC_CHAR = 2'd2;
    localparam logic [1:0] SRC_TRL  = 2'd3;

    typedef struct packed {
        logic             in_ready;
        logic             accept;
        logic             emit;
        logic [1:0]       src;
        logic [CNT_W-1:0] cnt;
        logic             last;
        logic             hdr_set;
        logic             idx_clr;
        logic             idx_inc;
        logic             fill_clr;
        logic             msg_clr;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic header_done;
        logic fill_nz;
        logic idx_last;
        logic in_dot;
        logic in_fin;
    } t_stat;

endpackage

@@ rtl/dqmb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqmb_ctrl
// Sequencer: walks header, label flush and trailer, one byte per cycle
// whenever the output register can take one.
// ----------------------------------------------------------------------------
module dqmb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  dqmb_pkg::t_stat i_stat,
    output dqmb_pkg::t_cmd  o_cmd
);
    import dqmb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDR   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_CHARS = 3'd3;
    localparam logic [2:0] S_TRL   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_dot, n_dot;
    logic             r_fin, n_fin;
    t_cmd             cmd;

    // where to go once the header is out (or was already out)
    function automatic logic [2:0] after_hdr(input logic dot, input logic fin,
                                             input logic fill_nz);
        logic [2:0] s;
        if (!fin) begin
            s = dot ? S_LEN : S_IDLE;
        end else begin
            s = (!dot || fill_nz) ? S_LEN : S_TRL;
        end
        return s;
    endfunction

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dot   = r_dot;
        n_fin   = r_fin;
        cmd     = '0;
        cmd.cnt = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.accept   = i_in_valid;
                if (i_in_valid) begin
                    n_dot = i_stat.in_dot;
                    n_fin = i_stat.in_fin;
                    n_cnt = '0;
                    if (!i_stat.header_done) begin
                        n_state = S_HDR;
                    end else begin
                        n_state = after_hdr(i_stat.in_dot, i_stat.in_fin,
                                            i_stat.fill_nz);
                    end
                end
            end
            S_HDR: begin
                cmd.src  = SRC_HDR;
                cmd.emit = i_stat.out_free;
                if (cmd.emit) begin
                    if (r_cnt == CNT_W'(HDR_LEN - 1)) begin
                        cmd.hdr_set = 1'b1;
                        n_cnt       = '0;
                        n_state     = after_hdr(r_dot, r_fin, i_stat.fill_nz);
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_LEN: begin
                cmd.src  = SRC_LEN;
                cmd.emit = i_stat.out_free;
                if (cmd.emit) begin
                    n_cnt = '0;
                    if (i_stat.fill_nz) begin
                        cmd.idx_clr = 1'b1;
                        n_state     = S_CHARS;
                    end else begin
                        n_state = r_fin ? S_TRL : S_IDLE;
                    end
                end
            end
            S_CHARS: begin
                cmd.src  = SRC_CHAR;
                cmd.emit = i_stat.out_free;
                if (cmd.emit) begin
                    cmd.idx_inc = 1'b1;
                    if (i_stat.idx_last) begin
                        cmd.fill_clr = 1'b1;
                        n_cnt        = '0;
                        n_state      = r_fin ? S_TRL : S_IDLE;
                    end
                end
            end
            S_TRL: begin
                cmd.src  = SRC_TRL;
                cmd.last = (r_cnt == CNT_W'(TRL_LEN - 1));
                cmd.emit = i_stat.out_free;
                if (cmd.emit) begin
                    if (cmd.last) begin
                        cmd.msg_clr = 1'b1;
                        n_cnt       = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dot   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dot   <= n_dot;
            r_fin   <= n_fin;
        end
    end

    assign o_cmd = cmd;

endmodule

@@ rtl/dqmb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqmb_datapath
// Config registers, label buffer, message state flags and the output register.
// ----------------------------------------------------------------------------
module dqmb_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dqmb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dqmb_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [dqmb_pkg::BYTE_W-1:0]       i_char,
    input  logic                              i_final,
    input  logic                              i_out_ready,
    input  dqmb_pkg::t_cmd                    i_cmd,
    output dqmb_pkg::t_stat                   o_stat,
    output logic                              o_out_valid,
    output logic [dqmb_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_out_last,
    output logic                              o_out_ovf
);
    import dqmb_pkg::*;

    // header byte positions
    localparam logic [CNT_W-1:0] HB_ID_HI = 4'd0;
    localparam logic [CNT_W-1:0] HB_ID_LO = 4'd1;
    localparam logic [CNT_W-1:0] HB_FL_HI = 4'd2;
    localparam logic [CNT_W-1:0] HB_FL_LO = 4'd3;
    localparam logic [CNT_W-1:0] HB_QD_LO = 4'd5;
    // trailer byte positions (position 0 is the root terminator)
    localparam logic [CNT_W-1:0] TB_QT_HI = 4'd1;
    localparam logic [CNT_W-1:0] TB_QT_LO = 4'd2;
    localparam logic [CNT_W-1:0] TB_QC_HI = 4'd3;
    localparam logic [CNT_W-1:0] TB_QC_LO = 4'd4;

    logic [CFG_W-1:0]  r_query_id, r_hdr_flags, r_qtype, r_qclass;
    logic [BYTE_W-1:0] r_label_mem [MAX_LABEL];
    logic [BYTE_W-1:0] r_rd_data;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic              r_hdr_done;
    logic              r_ovf;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_ovf;

    logic              in_dot;
    logic              fill_full;
    logic              store;
    logic [FILL_W-1:0] idx_next;
    logic [FILL_W-1:0] rd_idx;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W-1:0] trl_byte;
    logic [BYTE_W-1:0] n_byte;
    logic              out_free;

    assign in_dot    = (i_char == DOT_CHAR);
    assign fill_full = (r_fill == FILL_W'(MAX_LABEL));
    assign store     = i_cmd.accept && !in_dot && !fill_full;
    assign idx_next  = r_idx + 1'b1;
    assign out_free  = !r_out_valid || i_out_ready;

    // read address runs one ahead of the emit so data is ready when needed
    always_comb begin
        priority if (i_cmd.idx_clr) begin
            rd_idx = '0;
        end else if (i_cmd.idx_inc) begin
            rd_idx = idx_next;
        end else begin
            rd_idx = r_idx;
        end
    end

    always_comb begin
        unique case (i_cmd.cnt)
            HB_ID_HI: hdr_byte = r_query_id[15:8];
            HB_ID_LO: hdr_byte = r_query_id[7:0];
            HB_FL_HI: hdr_byte = r_hdr_flags[15:8];
            HB_FL_LO: hdr_byte = r_hdr_flags[7:0];
            HB_QD_LO: hdr_byte = 8'h01;           // question count = 1
            default:  hdr_byte = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.cnt)
            TB_QT_HI: trl_byte = r_qtype[15:8];
            TB_QT_LO: trl_byte = r_qtype[7:0];
            TB_QC_HI: trl_byte = r_qclass[15:8];
            TB_QC_LO: trl_byte = r_qclass[7:0];
            default:  trl_byte = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.src)
            SRC_HDR:  n_byte = hdr_byte;
            SRC_LEN:  n_byte = BYTE_W'(r_fill);
            SRC_CHAR: n_byte = r_rd_data;
            SRC_TRL:  n_byte = trl_byte;
            default:  n_byte = '0;
        endcase
    end

    // label buffer
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_label_mem[r_fill[LABEL_AW-1:0]] <= i_char;
        end
        r_rd_data <= r_label_mem[rd_idx[LABEL_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_id  <= RST_QUERY_ID;
            r_hdr_flags <= RST_HEADER_FLAGS;
            r_qtype     <= RST_QUESTION_TYPE;
            r_qclass    <= RST_QUESTION_CLASS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QUERY_ID:       r_query_id  <= i_cfg_data;
                CFG_HEADER_FLAGS:   r_hdr_flags <= i_cfg_data;
                CFG_QUESTION_TYPE:  r_qtype     <= i_cfg_data;
                CFG_QUESTION_CLASS: r_qclass    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_idx      <= '0;
            r_hdr_done <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            if (store) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.fill_clr || i_cmd.msg_clr) begin
                r_fill <= '0;
            end
            if (i_cmd.accept && !in_dot && fill_full) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.msg_clr) begin
                r_ovf <= 1'b0;
            end
            if (i_cmd.hdr_set) begin
                r_hdr_done <= 1'b1;
            end else if (i_cmd.msg_clr) begin
                r_hdr_done <= 1'b0;
            end
            r_idx <= rd_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= n_byte;
            r_out_last <= i_cmd.last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_stat.out_free    = out_free;
    assign o_stat.header_done = r_hdr_done;
    assign o_stat.fill_nz     = (r_fill != '0);
    assign o_stat.idx_last    = (idx_next == r_fill);
    assign o_stat.in_dot      = in_dot;
    assign o_stat.in_fin      = i_final;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

@@ rtl/dns_query_message_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_message_builder
// Builds a DNS query message byte by byte from a dotted hostname stream.
// ----------------------------------------------------------------------------
// Hostname characters come in on the slave stream, one per transfer, with
// tlast on the final character. The first character of a name produces the
// 12-byte header (id, flags, one question, zero counts). Characters are
// buffered in a MAX_LABEL-byte label buffer; a dot, or the final character,
// flushes the label as a length byte plus its characters. After the last
// label come the zero terminator, the query type and the query class (high
// byte first), with tlast on the final class byte. Characters past
// MAX_LABEL in one label are dropped and tuser stays high on every byte of
// that message from then on. A dot or final character starts the flush of
// the label, a length byte and then its characters (a final dot with
// nothing buffered skips the flush); the header goes out before it on the
// first character of a name and the trailer after it on the final one.
// One byte leaves the output register per cycle while the downstream side
// takes it, and the input is not taken while the sequencer still has bytes
// to send. A config write may be made only while no message is in
// progress.
// ----------------------------------------------------------------------------
module dns_query_message_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [dqmb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dqmb_pkg::CFG_W-1:0]     i_cfg_data,
    // hostname character stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] name_char
    input  logic                           s_axis_tlast,  // final_char
    // message byte stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
    output logic                           m_axis_tlast,  // message_end
    output logic                           m_axis_tuser   // [0] label_overflow
);
    import dqmb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dqmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dqmb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_final     (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;

    // a byte is only pushed when the output register has room
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("byte pushed into a full output register");

    // no new character while bytes of the previous one are being produced
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |-> !cmd.emit)
        else $error("character taken while output sequence busy");

    // end of message returns the builder to its start-of-name state
    a_msg_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.last) |=> (!stat.header_done && !stat.fill_nz))
        else $error("message state not cleared after final byte");

    // the end of a message is only ever flagged on a trailer byte
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.last) |-> (cmd.src == SRC_TRL))
        else $error("message end flagged outside the trailer");

endmodule
